>>> rtl/hfvp_pkg.sv
// hfvp_pkg: shared types and constants for the hash frame varint parser.
// No dependencies; used by hfvp_step and hash_frame_varint_parser.
package hfvp_pkg;

  // Width of the digest byte counter.
  localparam int unsigned COUNT_WIDTH = 32;

  // Varint byte index: 0..9.
  localparam int unsigned IDX_WIDTH = 4;
  localparam logic [IDX_WIDTH-1:0] VARINT_LAST_IDX = IDX_WIDTH'(9);

  // Frame parse phase, one-hot.
  typedef enum logic [2:0] {
    PH_CODE   = 3'b001,
    PH_LEN    = 3'b010,
    PH_DIGEST = 3'b100
  } phase_e;

  // Frame status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_ENDED    = 3'd2,
    ST_LONG     = 3'd3,
    ST_MISMATCH = 3'd4
  } status_e;

  // Per-frame parse state.
  typedef struct packed {
    phase_e                 phase;
    logic [63:0]            accum;
    logic [IDX_WIDTH-1:0]   idx;
    logic [63:0]            code;
    logic [63:0]            len;
    logic [COUNT_WIDTH-1:0] count;
    status_e                err;
    logic                   first;
  } frame_state_t;

  // One result transaction.
  typedef struct packed {
    logic        digest_valid;
    logic [7:0]  digest_byte;
    logic        frame_done;
    status_e     status;
    logic [63:0] hash_code;
    logic [63:0] digest_length;
  } result_t;

  localparam frame_state_t FRAME_RESET = '{
    phase: PH_CODE,
    accum: '0,
    idx:   '0,
    code:  '0,
    len:   '0,
    count: '0,
    err:   ST_OK,
    first: 1'b1
  };

endpackage

>>> rtl/hash_frame_varint_parser.sv
// hash_frame_varint_parser: streaming multihash-style frame decoder, top level.
// Depends on hfvp_pkg and hfvp_step.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one frame byte per
//   transaction, with in_last_i set on the frame's final byte. The frame is
//   a LEB128 hash code, a LEB128 digest length, then the digest bytes.
//   Output channel (out_valid_o/out_ready_i) carries one transaction per
//   digest byte passed through, and one for the last byte of each frame
//   with frame_done_o set, status_o, hash_code_o and digest_length_o.
//   Header bytes that do not end the frame produce no output transaction.
// Registered output: a result appears in the output register in the cycle
//   after its byte is taken.
// Throughput: one byte per cycle unless stalled; parse state update (shift,
//   OR, compare) is a single combinational step between the state registers.
// Stall: in_ready_o is high while the output register is empty or being
//   drained this cycle; if the receiver holds out_ready_i low with a result
//   pending, input is held off and the result stays stable.
// Reset: rst_ni (async, active low) empties the output register and returns
//   the parse state to the start of a frame.
module hash_frame_varint_parser import hfvp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        digest_valid_o,
  output logic [7:0]  digest_byte_o,
  output logic        frame_done_o,
  output logic [2:0]  status_o,
  output logic [63:0] hash_code_o,
  output logic [63:0] digest_length_o
);

  frame_state_t state_q, state_d;
  result_t      res_q, res_d;
  logic         out_valid_q, out_valid_d;
  logic         emit;
  logic         accept;

  // Frame parse logic for the byte on the input port.
  hfvp_step u_step (
    .cur_i  (state_q),
    .byte_i (in_byte_i),
    .last_i (in_last_i),
    .nxt_o  (state_d),
    .emit_o (emit),
    .res_o  (res_d)
  );

  // Output register frees when empty or taken this cycle.
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Parse state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FRAME_RESET;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        state_q <= state_d;
      end
    end
  end

  // Result payload, loaded only with a new result.
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign digest_valid_o  = res_q.digest_valid;
  assign digest_byte_o   = res_q.digest_byte;
  assign frame_done_o    = res_q.frame_done;
  assign status_o        = res_q.status;
  assign hash_code_o     = res_q.hash_code;
  assign digest_length_o = res_q.digest_length;

endmodule

>>> rtl/hfvp_step.sv
// hfvp_step: next-state and result logic for one frame byte.
// Depends on hfvp_pkg.
module hfvp_step import hfvp_pkg::*; (
  input  frame_state_t cur_i,
  input  logic [7:0]   byte_i,
  input  logic         last_i,
  output frame_state_t nxt_o,
  output logic         emit_o,
  output result_t      res_o
);

  frame_state_t upd;
  logic         pass;
  logic [5:0]   shamt;
  logic [63:0]  cont_bits;
  logic [63:0]  term_val;
  status_e      st;

  assign shamt     = 6'(7 * int'(cur_i.idx));
  assign cont_bits = 64'(byte_i[6:0]) << shamt;
  assign term_val  = cur_i.accum | (64'(byte_i) << shamt);

  // Byte update, before end-of-frame handling.
  always_comb begin
    upd  = cur_i;
    pass = 1'b0;
    if (cur_i.err == ST_OK) begin
      if (cur_i.phase != PH_DIGEST) begin
        if (byte_i[7]) begin
          if (cur_i.idx >= VARINT_LAST_IDX) begin
            upd.err = ST_LONG;
          end else begin
            upd.accum = cur_i.accum | cont_bits;
            upd.idx   = cur_i.idx + 1'b1;
          end
        end else if (cur_i.idx >= VARINT_LAST_IDX && byte_i > 8'd1) begin
          upd.err = ST_LONG;
        end else begin
          if (cur_i.phase == PH_CODE) begin
            upd.code  = term_val;
            upd.phase = PH_LEN;
          end else begin
            upd.len   = term_val;
            upd.phase = PH_DIGEST;
          end
          upd.accum = '0;
          upd.idx   = '0;
        end
      end else if (64'(cur_i.count) == cur_i.len || (&cur_i.count)) begin
        upd.err = ST_MISMATCH;
      end else begin
        pass      = 1'b1;
        upd.count = cur_i.count + 1'b1;
      end
    end
  end

  // Frame status on the last byte.
  always_comb begin
    priority if (cur_i.first) begin
      st = ST_SHORT;
    end else if (upd.err != ST_OK) begin
      st = upd.err;
    end else if (upd.phase != PH_DIGEST) begin
      st = ST_ENDED;
    end else if (64'(upd.count) != upd.len) begin
      st = ST_MISMATCH;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    res_o.digest_valid  = pass;
    res_o.digest_byte   = pass ? byte_i : 8'd0;
    res_o.frame_done    = last_i;
    res_o.status        = last_i ? st : ST_OK;
    res_o.hash_code     = (last_i && st == ST_OK) ? upd.code : 64'd0;
    res_o.digest_length = last_i ? upd.len : 64'd0;
    emit_o              = last_i | pass;
    if (last_i) begin
      nxt_o = FRAME_RESET;
    end else begin
      nxt_o       = upd;
      nxt_o.first = 1'b0;
    end
  end

endmodule
